### hw/rtl/word_clock_face_mask_unit_assert.svh
// ----------------------------------------------------------------------------
// Word clock face mask unit: assertion macros
// Property macros for the checker of the word clock face mask unit.
// Each macro samples on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WORD_CLOCK_FACE_MASK_UNIT_ASSERT_SVH
`define WORD_CLOCK_FACE_MASK_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("word clock face mask check failed");

// Next-cycle implication.
`define WCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("word clock face mask check failed");

`endif

### hw/rtl/wcf_pkg.sv
// ----------------------------------------------------------------------------
// Word clock face mask package
// Face geometry, word positions and lookup tables of the 24 by 24 face.
// ----------------------------------------------------------------------------
package wcf_pkg;

  // Face geometry.
  localparam int GridColumns = 24;
  localparam int GridRows    = 24;
  localparam int AddrW       = 10;
  localparam int LenW        = 4;
  localparam int RowW        = 5;
  localparam logic [RowW-1:0] LastRow = RowW'(GridRows - 1);

  // Time boundaries.
  localparam logic [5:0] HalfHour      = 6'd30;
  localparam logic [4:0] AfternoonFrom = 5'd12;
  localparam logic [4:0] EveningFrom   = 5'd18;
  localparam logic [4:0] NightFrom     = 5'd22;

  // A word: first letter position and letter count.
  typedef struct packed {
    logic [AddrW-1:0] at;
    logic [LenW-1:0]  len;
  } word_t;

  // A word as a half-open letter range [lo, hi).
  typedef struct packed {
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
  } span_t;

  localparam word_t NoWord        = '{at: 10'd0,   len: 4'd0};
  localparam word_t WordIt        = '{at: 10'd0,   len: 4'd2};
  localparam word_t WordIs        = '{at: 10'd3,   len: 4'd2};
  localparam word_t WordDayThe    = '{at: 10'd69,  len: 4'd3};
  localparam word_t WordOf        = '{at: 10'd253, len: 4'd2};
  localparam word_t WordTimeThe   = '{at: 10'd336, len: 4'd3};
  localparam word_t WordTime      = '{at: 10'd340, len: 4'd4};
  localparam word_t WordTimeIs    = '{at: 10'd345, len: 4'd2};
  localparam word_t WordHalf      = '{at: 10'd356, len: 4'd4};
  localparam word_t WordMinTwenty = '{at: 10'd362, len: 4'd6};
  localparam word_t WordPast      = '{at: 10'd452, len: 4'd4};
  localparam word_t WordTo        = '{at: 10'd456, len: 4'd2};
  localparam word_t WordOclock    = '{at: 10'd521, len: 4'd7};
  localparam word_t WordAt        = '{at: 10'd528, len: 4'd2};
  localparam word_t WordNight     = '{at: 10'd531, len: 4'd5};
  localparam word_t WordIn        = '{at: 10'd537, len: 4'd2};
  localparam word_t WordPerThe    = '{at: 10'd540, len: 4'd3};
  localparam word_t WordMorning   = '{at: 10'd544, len: 4'd7};
  localparam word_t WordEvening   = '{at: 10'd553, len: 4'd7};
  localparam word_t WordAfternoon = '{at: 10'd561, len: 4'd9};
  localparam word_t WordDayTwenty = '{at: 10'd72,  len: 4'd6};
  localparam word_t WordThirtieth = '{at: 10'd87,  len: 4'd9};
  localparam word_t WordThirty    = '{at: 10'd96,  len: 4'd6};

  // Sunday through Saturday.
  localparam word_t WeekdayWords [7] = '{
    '{10'd24, 4'd6}, '{10'd61, 4'd6}, '{10'd7, 4'd7}, '{10'd50, 4'd9},
    '{10'd15, 4'd8}, '{10'd32, 4'd6}, '{10'd39, 4'd8}
  };

  // January through December.
  localparam word_t MonthWords [12] = '{
    '{10'd264, 4'd7}, '{10'd275, 4'd8}, '{10'd327, 4'd5}, '{10'd283, 4'd5},
    '{10'd271, 4'd3}, '{10'd332, 4'd4}, '{10'd322, 4'd4}, '{10'd288, 4'd6},
    '{10'd303, 4'd9}, '{10'd295, 4'd7}, '{10'd256, 4'd8}, '{10'd314, 4'd8}
  };

  // FIRST through TWENTIETH at their own index; entry zero is blank.
  localparam word_t OrdinalWords [21] = '{
    '{10'd0, 4'd0},    '{10'd192, 4'd5},  '{10'd113, 4'd6}, '{10'd198, 4'd5},
    '{10'd120, 4'd6},  '{10'd221, 4'd5},  '{10'd187, 4'd5}, '{10'd233, 4'd7},
    '{10'd241, 4'd6},  '{10'd247, 4'd5},  '{10'd216, 4'd5}, '{10'd127, 4'd8},
    '{10'd226, 4'd7},  '{10'd177, 4'd10}, '{10'd157, 4'd10}, '{10'd135, 4'd9},
    '{10'd168, 4'd9},  '{10'd204, 4'd11}, '{10'd146, 4'd10}, '{10'd103, 4'd10},
    '{10'd78, 4'd9}
  };

  // ONE through NINETEEN at their own index; the fifteen entry is QUARTER.
  localparam word_t MinuteWords [20] = '{
    '{10'd0, 4'd0},   '{10'd381, 4'd3}, '{10'd379, 4'd3}, '{10'd446, 4'd5},
    '{10'd415, 4'd4}, '{10'd394, 4'd4}, '{10'd372, 4'd3}, '{10'd384, 4'd5},
    '{10'd424, 4'd5}, '{10'd398, 4'd4}, '{10'd369, 4'd3}, '{10'd432, 4'd6},
    '{10'd408, 4'd6}, '{10'd438, 4'd8}, '{10'd415, 4'd8}, '{10'd349, 4'd7},
    '{10'd372, 4'd7}, '{10'd384, 4'd9}, '{10'd424, 4'd8}, '{10'd398, 4'd8}
  };

  // TWELVE, then ONE through ELEVEN.
  localparam word_t HourWords [12] = '{
    '{10'd506, 4'd6}, '{10'd485, 4'd3}, '{10'd470, 4'd3}, '{10'd459, 4'd5},
    '{10'd480, 4'd4}, '{10'd499, 4'd4}, '{10'd492, 4'd3}, '{10'd465, 4'd5},
    '{10'd514, 4'd5}, '{10'd488, 4'd4}, '{10'd495, 4'd3}, '{10'd474, 4'd6}
  };

  // Turns a word into its letter range.
  function automatic span_t span_of(word_t w);
    span_t s;
    s.lo = w.at;
    s.hi = w.at + AddrW'(w.len);
    return s;
  endfunction

endpackage

### hw/rtl/wcf_if.sv
// ----------------------------------------------------------------------------
// Word clock face mask channels
// Valid/ready channels for the date and time input and the row mask output.
// ----------------------------------------------------------------------------

// Date and time input channel.
interface wcf_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] day_of_month;
  logic [3:0] month;
  logic [2:0] weekday;

  modport source (output valid, minute, hour, day_of_month, month, weekday,
                  input ready);
  modport sink   (input valid, minute, hour, day_of_month, month, weekday,
                  output ready);
endinterface

// Row mask output channel.
interface wcf_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  row_index;
  logic [23:0] row_bits;
  logic        last_row;

  modport source (output valid, row_index, row_bits, last_row, input ready);
  modport sink   (input valid, row_index, row_bits, last_row, output ready);
endinterface

### hw/rtl/word_clock_face_mask_unit.sv
// ----------------------------------------------------------------------------
// Word clock face mask unit
// Builds the lit-letter mask of a 24 by 24 word clock face from a date and time.
// ----------------------------------------------------------------------------
// Each input beat gives 24 output beats, rows 0 to 23 in order, the last one
// marked by last_row. At the input beat the date and time are decoded into
// the letter ranges of the lit words and held in a word register; every
// cycle one row is then masked against those ranges and loaded into the
// result register; the first row of an item passes the word register and
// then the result register. The next input beat is taken in the cycle in
// which the last row of the current item enters the result register, so with
// an always-ready sink the block delivers one row every cycle without gaps.
// Backpressure on the output stalls the row sweep one-for-one.
// ----------------------------------------------------------------------------
module word_clock_face_mask_unit import wcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  wcf_in_if.sink    item_i,
  wcf_out_if.source row_o
);

  // Slots of the word register, one per word that may be lit.
  typedef enum logic [4:0] {
    SlotIt, SlotIs, SlotWeekday, SlotDayThe, SlotDayA, SlotDayB, SlotOf,
    SlotMonth, SlotTimeThe, SlotTime, SlotTimeIs, SlotMinA, SlotMinB,
    SlotLink, SlotHour, SlotPerA, SlotPerB, SlotPeriod
  } slot_e;

  localparam int NumSlots = 18;

  // Letters of one row that fall inside a range.
  function automatic logic [GridColumns-1:0] row_mask(span_t s, logic [AddrW-1:0] base);
    logic [AddrW-1:0]       k;
    logic [GridColumns-1:0] m;
    for (int c = 0; c < GridColumns; c++) begin
      k    = base + AddrW'(c);
      m[c] = (k >= s.lo) && (k < s.hi);
    end
    return m;
  endfunction

  word_t                  words    [NumSlots];
  span_t                  spans_d  [NumSlots];
  span_t                  spans_q  [NumSlots];
  logic [5:0]             mirror_min;
  logic [5:0]             hour_adv;
  logic [3:0]             hour_idx;
  logic                   busy_q, busy_d;
  logic [RowW-1:0]        row_q, row_d;
  logic                   out_valid_q, out_valid_d;
  logic [RowW-1:0]        out_row_q;
  logic [GridColumns-1:0] out_bits_q;
  logic                   out_last_q;
  logic                   load;
  logic                   last_load;
  logic                   in_ready;
  logic                   accept;
  logic [AddrW-1:0]       row_base;
  logic [GridColumns-1:0] row_bits_d;

  // Minute mirrored about the half hour, and the hour that the face names.
  always_comb begin
    mirror_min = (item_i.minute <= HalfHour) ? item_i.minute : 6'd60 - item_i.minute;
    hour_adv   = {1'b0, item_i.hour} + {5'b0, item_i.minute > HalfHour};
    priority if (hour_adv >= 6'd24) begin
      hour_idx = 4'(hour_adv - 6'd24);
    end else if (hour_adv >= 6'd12) begin
      hour_idx = 4'(hour_adv - 6'd12);
    end else begin
      hour_idx = hour_adv[3:0];
    end
  end

  // Word selection for the incoming beat.
  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      words[i] = NoWord;
    end
    words[SlotIt]      = WordIt;
    words[SlotIs]      = WordIs;
    words[SlotDayThe]  = WordDayThe;
    words[SlotOf]      = WordOf;
    words[SlotTimeThe] = WordTimeThe;
    words[SlotTime]    = WordTime;
    words[SlotTimeIs]  = WordTimeIs;

    if (item_i.weekday != 3'd7) begin
      words[SlotWeekday] = WeekdayWords[item_i.weekday];
    end
    if (item_i.month < 4'd12) begin
      words[SlotMonth] = MonthWords[item_i.month];
    end

    // Ordinal day; a day of zero lights nothing.
    priority if (item_i.day_of_month == 5'd0) begin
      words[SlotDayA] = NoWord;
    end else if (item_i.day_of_month <= 5'd20) begin
      words[SlotDayA] = OrdinalWords[item_i.day_of_month];
    end else if (item_i.day_of_month <= 5'd29) begin
      words[SlotDayA] = WordDayTwenty;
      words[SlotDayB] = OrdinalWords[item_i.day_of_month - 5'd20];
    end else if (item_i.day_of_month == 5'd30) begin
      words[SlotDayA] = WordThirtieth;
    end else begin
      words[SlotDayA] = WordThirty;
      words[SlotDayB] = OrdinalWords[1];
    end

    // Minute words; on the hour and for minutes past the range nothing.
    if (item_i.minute != 6'd0 && item_i.minute < 6'd60) begin
      priority if (mirror_min == HalfHour) begin
        words[SlotMinA] = WordHalf;
      end else if (mirror_min < 6'd20) begin
        words[SlotMinA] = MinuteWords[mirror_min[4:0]];
      end else begin
        words[SlotMinA] = WordMinTwenty;
        if (mirror_min != 6'd20) begin
          words[SlotMinB] = MinuteWords[5'(mirror_min - 6'd20)];
        end
      end
    end

    // PAST, TO or O'CLOCK, then the hour word.
    priority if (item_i.minute == 6'd0) begin
      words[SlotLink] = WordOclock;
    end else if (item_i.minute <= HalfHour) begin
      words[SlotLink] = WordPast;
    end else begin
      words[SlotLink] = WordTo;
    end
    words[SlotHour] = HourWords[hour_idx];

    // Part of the day.
    if (item_i.hour < NightFrom) begin
      words[SlotPerA] = WordIn;
      words[SlotPerB] = WordPerThe;
    end else begin
      words[SlotPerA] = WordAt;
    end
    priority if (item_i.hour < AfternoonFrom) begin
      words[SlotPeriod] = WordMorning;
    end else if (item_i.hour < EveningFrom) begin
      words[SlotPeriod] = WordAfternoon;
    end else if (item_i.hour < NightFrom) begin
      words[SlotPeriod] = WordEvening;
    end else begin
      words[SlotPeriod] = WordNight;
    end

    for (int i = 0; i < NumSlots; i++) begin
      spans_d[i] = span_of(words[i]);
    end
  end

  // Handshake and row sweep control.
  assign load      = busy_q && (!out_valid_q || row_o.ready);
  assign last_load = load && (row_q == LastRow);
  assign in_ready  = !busy_q || last_load;
  assign accept    = item_i.valid && in_ready;

  always_comb begin
    busy_d      = busy_q;
    row_d       = row_q;
    out_valid_d = out_valid_q;
    if (load) begin
      row_d = row_q + RowW'(1);
    end
    if (last_load) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      row_d  = '0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (row_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Row mask of the current row.
  assign row_base = AddrW'({row_q, 4'b0}) + AddrW'({row_q, 3'b0});

  always_comb begin
    row_bits_d = '0;
    for (int i = 0; i < NumSlots; i++) begin
      row_bits_d = row_bits_d | row_mask(spans_q[i], row_base);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Word register and result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      spans_q <= spans_d;
    end
    if (load) begin
      out_row_q  <= row_q;
      out_bits_q <= row_bits_d;
      out_last_q <= (row_q == LastRow);
    end
  end

  assign item_i.ready    = in_ready;
  assign row_o.valid     = out_valid_q;
  assign row_o.row_index = out_row_q;
  assign row_o.row_bits  = out_bits_q;
  assign row_o.last_row  = out_last_q;

endmodule

### hw/rtl/wcf_checker.sv
// ----------------------------------------------------------------------------
// Word clock face mask checker
// Port-level checks of row order, last-row mark, idle readiness, item overlap
// and stall hold, bound to the top level.
// ----------------------------------------------------------------------------
`include "word_clock_face_mask_unit_assert.svh"

module wcf_checker import wcf_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [RowW-1:0]        out_row_index_i,
  input logic [GridColumns-1:0] out_row_bits_i,
  input logic                   out_last_row_i
);

  logic            in_beat;
  logic            out_beat;
  logic [6:0]      owed_q, owed_d;
  logic [RowW-1:0] exp_row_q, exp_row_d;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Rows still owed to the sink and the row index expected next.
  always_comb begin
    owed_d    = owed_q + (in_beat ? 7'(GridRows) : 7'd0) - (out_beat ? 7'd1 : 7'd0);
    exp_row_d = exp_row_q;
    if (out_beat) begin
      exp_row_d = out_last_row_i ? '0 : exp_row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q    <= '0;
      exp_row_q <= '0;
    end else begin
      owed_q    <= owed_d;
      exp_row_q <= exp_row_d;
    end
  end

  // Rows come out in order, the last one marked.
  `WCF_ASSERT_IMP(row_in_order_a, out_valid_i, out_row_index_i == exp_row_q)
  `WCF_ASSERT_IMP(last_row_mark_a, out_valid_i, out_last_row_i == (out_row_index_i == LastRow))
  // An idle block takes a beat, and a new item overlaps only the tail of the last one.
  `WCF_ASSERT_IMP(idle_ready_a, owed_q == 7'd0, in_ready_i)
  `WCF_ASSERT_IMP(overlap_bound_a, in_beat, owed_q <= 7'd2)
  // A stalled row holds its mask.
  `WCF_ASSERT_NXT(stall_hold_a, out_valid_i && !out_ready_i, out_valid_i && $stable(out_row_bits_i))

endmodule

bind word_clock_face_mask_unit wcf_checker u_wcf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (row_o.valid),
  .out_ready_i    (row_o.ready),
  .out_row_index_i(row_o.row_index),
  .out_row_bits_i (row_o.row_bits),
  .out_last_row_i (row_o.last_row)
);
